// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/thc_pkg.sv =====
// Types, register indexes and constants of the temperature and humidity compensation block.
package thc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } thc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [9:0]         humidity_permille;
  } thc_out_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF_ONE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF_TWO      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF_THREE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEF_ONE_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEF_TWO       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEF_FOUR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEF_FIVE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_COEF_SIX       = 3'd7;

  // Number of register stages from the input to the result register.
  localparam int unsigned NUM_STAGES = 13;

  localparam logic [24:0] TEMP_ROUND   = 25'd128;
  localparam logic [22:0] HUM_X_OFFSET = 23'd76800;
  localparam logic [36:0] HUM_A_ROUND  = 37'd16384;
  localparam logic [21:0] HUM_C_OFFSET = 22'd32768;
  localparam logic [33:0] HUM_B_OFFSET = 34'd2097152;
  localparam logic [50:0] HUM_B_ROUND  = 51'd8192;
  localparam logic [63:0] HUM_MAX      = 64'd419430400;
  localparam logic [10:0] PERMILLE_MAX = 11'd1000;

endpackage

// ===== sv/temp_humidity_compensation.sv =====
// Top level of the temperature and humidity compensation block: a 13-stage pipeline.
//
// Takes one raw temperature and humidity pair per item and returns the temperature in
// hundredths of a degree Celsius (saturated to 16-bit signed) and the relative humidity
// in permille (0 to 1000). The block accepts one item every clock cycle while the input is
// not stalled and holds up to 13 items in flight; each result passes through the stages
// in order and is taken from the result register when the output is not stalled. A stall
// at the output fills empty stages first; the input stalls only when all 13 stages hold
// an item and the output is stalled.
// Calibration registers are written through the cfg_ port and must only change while no
// item is in flight.
`include "assert_macros.svh"

module temp_humidity_compensation (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  thc_pkg::thc_in_t                       in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output thc_pkg::thc_out_t                      out_data,
  input  logic                                   cfg_we,
  input  logic [thc_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [thc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int unsigned NS = thc_pkg::NUM_STAGES;

  // Calibration registers.
  logic        [15:0] t1_r;
  logic signed [15:0] t2_r;
  logic signed [15:0] t3_r;
  logic        [15:0] h13_r;
  logic signed [15:0] h2_r;
  logic signed [11:0] h4_r;
  logic signed [11:0] h5_r;
  logic signed [7:0]  h6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r  <= '0;
      t2_r  <= '0;
      t3_r  <= '0;
      h13_r <= '0;
      h2_r  <= '0;
      h4_r  <= '0;
      h5_r  <= '0;
      h6_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        thc_pkg::REG_TEMP_COEF_ONE:      t1_r  <= cfg_data;
        thc_pkg::REG_TEMP_COEF_TWO:      t2_r  <= cfg_data;
        thc_pkg::REG_TEMP_COEF_THREE:    t3_r  <= cfg_data;
        thc_pkg::REG_HUM_COEF_ONE_THREE: h13_r <= cfg_data;
        thc_pkg::REG_HUM_COEF_TWO:       h2_r  <= cfg_data;
        thc_pkg::REG_HUM_COEF_FOUR:      h4_r  <= cfg_data[11:0];
        thc_pkg::REG_HUM_COEF_FIVE:      h5_r  <= cfg_data[11:0];
        thc_pkg::REG_HUM_COEF_SIX:       h6_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage may load when it is empty or its successor loads.
  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_nxt;
  logic [NS-1:0] ready;

  always_comb begin
    ready[NS-1] = !valid_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = ready[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NS; k++) begin
      valid_nxt[k] = ready[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid_r[NS-1];

  // Stage 0: temperature differences and first products.
  logic signed [17:0] c1_tdiff;
  logic signed [16:0] c1_d;
  logic signed [33:0] c1_pv1;
  logic signed [33:0] c1_pdd;
  logic signed [33:0] s0_pv1_r;
  logic signed [33:0] s0_pdd_r;
  logic        [15:0] s0_hum_r;

  assign c1_tdiff = $signed({1'b0, in_data.raw_temperature[19:3]}) -
                    $signed({1'b0, t1_r, 1'b0});
  assign c1_d     = $signed({1'b0, in_data.raw_temperature[19:4]}) - $signed({1'b0, t1_r});
  assign c1_pv1   = c1_tdiff * t2_r;
  assign c1_pdd   = c1_d * c1_d;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      s0_pv1_r <= c1_pv1;
      s0_pdd_r <= c1_pdd;
      s0_hum_r <= in_data.raw_humidity;
    end
  end

  // Stage 1: the 32-bit wrapped square is shifted and scaled by the quadratic term.
  logic signed [19:0] c2_dd;
  logic signed [35:0] c2_pv2;
  logic        [20:0] s1_v1_r;
  logic        [35:0] s1_pv2_r;
  logic        [15:0] s1_hum_r;

  assign c2_dd  = s0_pdd_r[31:12];
  assign c2_pv2 = c2_dd * t3_r;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      s1_v1_r  <= s0_pv1_r[31:11];
      s1_pv2_r <= c2_pv2;
      s1_hum_r <= s0_hum_r;
    end
  end

  // Stage 2: fine temperature. Both terms are small enough that the sum never wraps.
  logic [21:0] c3_fine;
  logic [21:0] s2_fine_r;
  logic [15:0] s2_hum_r;

  assign c3_fine = {s1_v1_r[20], s1_v1_r} + {{4{s1_pv2_r[31]}}, s1_pv2_r[31:14]};

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      s2_fine_r <= c3_fine;
      s2_hum_r  <= s1_hum_r;
    end
  end

  // Stage 3: centidegrees with saturation, and the humidity temperature term.
  logic [24:0]        c4_t5;
  logic [16:0]        c4_tc17;
  logic [15:0]        c4_tc;
  logic [22:0]        c4_x;
  logic signed [22:0] s3_x_r;
  logic        [15:0] s3_tc_r;
  logic        [15:0] s3_hum_r;

  assign c4_t5   = {{3{s2_fine_r[21]}}, s2_fine_r} + {s2_fine_r[21], s2_fine_r, 2'b00} +
                   thc_pkg::TEMP_ROUND;
  assign c4_tc17 = c4_t5[24:8];
  assign c4_x    = {s2_fine_r[21], s2_fine_r} - thc_pkg::HUM_X_OFFSET;

  always_comb begin
    if (c4_tc17[16] != c4_tc17[15]) begin
      c4_tc = c4_tc17[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      c4_tc = c4_tc17[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      s3_x_r   <= c4_x;
      s3_tc_r  <= c4_tc;
      s3_hum_r <= s2_hum_r;
    end
  end

  // Stage 4: the three products of the temperature term with humidity coefficients.
  logic signed [34:0] c5_ph5;
  logic signed [30:0] c5_ph6;
  logic signed [31:0] c5_ph3;
  logic        [34:0] s4_ph5_r;
  logic        [30:0] s4_ph6_r;
  logic        [31:0] s4_ph3_r;
  logic        [15:0] s4_tc_r;
  logic        [15:0] s4_hum_r;

  assign c5_ph5 = s3_x_r * h5_r;
  assign c5_ph6 = s3_x_r * h6_r;
  assign c5_ph3 = s3_x_r * $signed({1'b0, h13_r[15:8]});

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      s4_ph5_r <= c5_ph5;
      s4_ph6_r <= c5_ph6;
      s4_ph3_r <= c5_ph3;
      s4_tc_r  <= s3_tc_r;
      s4_hum_r <= s3_hum_r;
    end
  end

  // Stage 5: offset term, curvature term and the temperature factor.
  logic [36:0] c6_apre;
  logic [21:0] c6_c;
  logic [21:0] s5_a_r;
  logic [20:0] s5_b0_r;
  logic [21:0] s5_c_r;
  logic [15:0] s5_tc_r;

  assign c6_apre = {7'b0, s4_hum_r, 14'b0} - {{5{h4_r[11]}}, h4_r, 20'b0} -
                   {{2{s4_ph5_r[34]}}, s4_ph5_r} + thc_pkg::HUM_A_ROUND;
  assign c6_c    = {s4_ph3_r[31], s4_ph3_r[31:11]} + thc_pkg::HUM_C_OFFSET;

  always_ff @(posedge clk) begin
    if (ready[5]) begin
      s5_a_r  <= c6_apre[36:15];
      s5_b0_r <= s4_ph6_r[30:10];
      s5_c_r  <= c6_c;
      s5_tc_r <= s4_tc_r;
    end
  end

  // Stage 6: curvature times temperature factor.
  logic signed [42:0] c7_pbc;
  logic        [42:0] s6_pbc_r;
  logic        [21:0] s6_a_r;
  logic        [15:0] s6_tc_r;

  assign c7_pbc = $signed(s5_b0_r) * $signed(s5_c_r);

  always_ff @(posedge clk) begin
    if (ready[6]) begin
      s6_pbc_r <= c7_pbc;
      s6_a_r   <= s5_a_r;
      s6_tc_r  <= s5_tc_r;
    end
  end

  // Stage 7: gain coefficient.
  logic [33:0]        c8_b1;
  logic signed [49:0] c8_pbh2;
  logic        [49:0] s7_pbh2_r;
  logic        [21:0] s7_a_r;
  logic        [15:0] s7_tc_r;

  assign c8_b1   = {s6_pbc_r[42], s6_pbc_r[42:10]} + thc_pkg::HUM_B_OFFSET;
  assign c8_pbh2 = $signed(c8_b1) * h2_r;

  always_ff @(posedge clk) begin
    if (ready[7]) begin
      s7_pbh2_r <= c8_pbh2;
      s7_a_r    <= s6_a_r;
      s7_tc_r   <= s6_tc_r;
    end
  end

  // Stage 8: the uncorrected humidity value. Its exact width stays below 64 bits.
  logic [50:0]        c9_bsum;
  logic signed [58:0] c9_v;
  logic        [58:0] s8_v_r;
  logic        [15:0] s8_tc_r;

  assign c9_bsum = {s7_pbh2_r[49], s7_pbh2_r} + thc_pkg::HUM_B_ROUND;
  assign c9_v    = $signed(s7_a_r) * $signed(c9_bsum[50:14]);

  always_ff @(posedge clk) begin
    if (ready[8]) begin
      s8_v_r  <= c9_v;
      s8_tc_r <= s7_tc_r;
    end
  end

  // Stage 9: the square of v >>> 15 wraps at 64 bits, so it is built from halves.
  logic signed [21:0] c10_sh;
  logic        [21:0] c10_sl;
  logic signed [43:0] c10_pss;
  logic signed [44:0] c10_psl;
  logic        [43:0] c10_pll;
  logic        [19:0] s9_pss_r;
  logic        [40:0] s9_psl_r;
  logic        [43:0] s9_pll_r;
  logic        [58:0] s9_v_r;
  logic        [15:0] s9_tc_r;

  assign c10_sh  = s8_v_r[58:37];
  assign c10_sl  = s8_v_r[36:15];
  assign c10_pss = c10_sh * c10_sh;
  assign c10_psl = c10_sh * $signed({1'b0, c10_sl});
  assign c10_pll = c10_sl * c10_sl;

  always_ff @(posedge clk) begin
    if (ready[9]) begin
      s9_pss_r <= c10_pss[19:0];
      s9_psl_r <= c10_psl[40:0];
      s9_pll_r <= c10_pll;
      s9_v_r   <= s8_v_r;
      s9_tc_r  <= s8_tc_r;
    end
  end

  // Stage 10: recombine the partial products modulo 2^64.
  logic [63:0] c11_sq;
  logic [56:0] s10_sq7_r;
  logic [58:0] s10_v_r;
  logic [15:0] s10_tc_r;

  assign c11_sq = {s9_pss_r, 44'b0} + {s9_psl_r, 23'b0} + {20'b0, s9_pll_r};

  always_ff @(posedge clk) begin
    if (ready[10]) begin
      s10_sq7_r <= c11_sq[63:7];
      s10_v_r   <= s9_v_r;
      s10_tc_r  <= s9_tc_r;
    end
  end

  // Stage 11: saturation correction term.
  logic signed [65:0] c12_ph1;
  logic        [59:0] s11_ph1_r;
  logic        [58:0] s11_v_r;
  logic        [15:0] s11_tc_r;

  assign c12_ph1 = $signed(s10_sq7_r) * $signed({1'b0, h13_r[7:0]});

  always_ff @(posedge clk) begin
    if (ready[11]) begin
      s11_ph1_r <= c12_ph1[63:4];
      s11_v_r   <= s10_v_r;
      s11_tc_r  <= s10_tc_r;
    end
  end

  // Stage 12: clamp, scale to permille and cap.
  logic [63:0] c13_vf;
  logic [28:0] c13_vc;
  logic [20:0] c13_m;
  logic [10:0] c13_pm;
  logic [9:0]  c13_pm_cap;
  logic [15:0] s12_tc_r;
  logic [9:0]  s12_pm_r;

  assign c13_vf = {{5{s11_v_r[58]}}, s11_v_r} - {{4{s11_ph1_r[59]}}, s11_ph1_r};

  always_comb begin
    if (c13_vf[63]) begin
      c13_vc = '0;
    end else if (c13_vf > thc_pkg::HUM_MAX) begin
      c13_vc = thc_pkg::HUM_MAX[28:0];
    end else begin
      c13_vc = c13_vf[28:0];
    end
  end

  // Multiply by ten as two shifts, then divide by 1024.
  assign c13_m  = {1'b0, c13_vc[28:12], 3'b000} + {3'b000, c13_vc[28:12], 1'b0};
  assign c13_pm = c13_m[20:10];
  assign c13_pm_cap = (c13_pm > thc_pkg::PERMILLE_MAX) ? thc_pkg::PERMILLE_MAX[9:0]
                                                        : c13_pm[9:0];

  always_ff @(posedge clk) begin
    if (ready[12]) begin
      s12_tc_r <= s11_tc_r;
      s12_pm_r <= c13_pm_cap;
    end
  end

  assign out_data.temperature_centi = s12_tc_r;
  assign out_data.humidity_permille = s12_pm_r;

  `ASSERT_NEXT(a_accept_fills_first, clk, rst_n, in_valid && !in_stall, valid_r[0],
               "accepted item did not enter the first stage")
  `ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, in_stall, (&valid_r) && out_stall,
                "input stalled while the pipeline had a free stage")
  `ASSERT_NEXT(a_no_item_lost, clk, rst_n, !(out_valid && !out_stall),
               $countones(valid_r) >= $past($countones(valid_r)),
               "item dropped from the pipeline without being delivered")
  `ASSERT_IMPLY(a_permille_range, clk, rst_n, out_valid,
                out_data.humidity_permille <= thc_pkg::PERMILLE_MAX[9:0],
                "humidity result above 1000 permille")

endmodule
